// File: src/qph_pkg.sv
// shared types and constants for the quadratic probe hash table
package qph_pkg;

  // fixed field widths
  localparam int KEY_W      = 31;
  localparam int KIND_W     = 2;
  localparam int STATUS_W   = 2;
  localparam int SLOT_OUT_W = 10;
  localparam int LIMIT_W    = 10;

  // port widths, padded to whole bytes
  localparam int S_TDATA_W = 32;
  localparam int M_TDATA_W = 16;

  // load limit after reset
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 10'd817;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;

  // result codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISSING = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

  // one slot of the table
  typedef struct packed {
    logic             used;
    logic             dead;
    logic [KEY_W-1:0] key;
  } slot_t;

endpackage

// File: src/qph_home.sv
// key modulo table size by reciprocal multiplication, pipelined: multiply, multiply back, subtract
module qph_home import qph_pkg::*; #(
  parameter int TABLE_SLOTS = 1021,
  parameter int SLOT_W      = 10
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [KEY_W-1:0]  key,
  output logic              done,
  output logic [SLOT_W-1:0] home
);

  // rounded-up reciprocal, exact quotient for every key below 2**KEY_W
  localparam int SHIFT   = KEY_W + SLOT_W;
  localparam int RECIP_W = KEY_W + 1;
  localparam int PROD_W  = KEY_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << SHIFT) + 64'(TABLE_SLOTS) - 64'd1) / 64'(TABLE_SLOTS));

  logic [PROD_W-1:0] prod;
  logic [KEY_W-1:0]  key_d;
  logic [KEY_W-1:0]  quot;
  logic [KEY_W-1:0]  back;
  logic [SLOT_W-1:0] rem;
  logic              stage1;
  logic              stage2;

  assign quot = KEY_W'(prod >> SHIFT);

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      stage1 <= 1'b0;
      stage2 <= 1'b0;
      done   <= 1'b0;
    end else begin
      stage1 <= start;
      stage2 <= stage1;
      done   <= stage2;
    end
  end

  // multiply by the reciprocal, multiply back, subtract
  always_ff @(posedge clk) begin
    if (start) begin
      prod  <= {{RECIP_W{1'b0}}, key} * {{KEY_W{1'b0}}, RECIP};
      key_d <= key;
    end
    if (stage1) begin
      back <= quot * KEY_W'(TABLE_SLOTS);
    end
    if (stage2) begin
      rem <= SLOT_W'(key_d - back);
    end
  end

  assign home = rem;

endmodule

// File: src/qph_ram.sv
// slot store: one write port, one read port with registered data
module qph_ram import qph_pkg::*; #(
  parameter int DEPTH  = 1021,
  parameter int ADDR_W = 10
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  slot_t             wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output slot_t             rd_data
);

  slot_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: src/quadratic_probe_hash_table_unit.sv
// top level: request sequencer, probe address generator and result register
// steps: accept, home slot (key mod size by reciprocal multiply), probes, then the result register
// probes read one slot a cycle through the single ram read port; reads are issued ahead
// one request at a time; refused inserts go straight from accept to the result register
// reset: a clearing pass writes every slot empty, with s_tready low
// reset sets load_limit to 817 and the element count to zero
module quadratic_probe_hash_table_unit import qph_pkg::*; #(
  parameter int TABLE_SLOTS = 1021
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [S_TDATA_W-1:0]  s_tdata,   // key[30:0], zero pad
  input  logic [KIND_W-1:0]     s_tuser,   // req_type[1:0]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [M_TDATA_W-1:0]  m_tdata,   // status[1:0], slot_index[11:2], zero pad
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [LIMIT_W-1:0]    cfg_data   // load_limit[9:0]
);

  localparam int SLOT_W = $clog2(TABLE_SLOTS);
  localparam int PCNT_W = $clog2(TABLE_SLOTS + 1);
  localparam int CMP_W  = (PCNT_W > LIMIT_W) ? PCNT_W : LIMIT_W;

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_HOME   = 3'd2;
  localparam logic [2:0] ST_PROBE  = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  logic [2:0]            state;
  logic [LIMIT_W-1:0]    load_limit;
  logic [PCNT_W-1:0]     element_count;
  logic [SLOT_W-1:0]     clr_addr;
  logic [KIND_W-1:0]     req_kind;
  logic [KEY_W-1:0]      req_key;
  logic [SLOT_W-1:0]     pslot;
  logic [SLOT_W-1:0]     stride;
  logic [PCNT_W-1:0]     issued;
  logic                  rd_vld;
  logic                  rd_last;
  logic [SLOT_W-1:0]     rd_slot;
  logic [STATUS_W-1:0]   res_status;
  logic [SLOT_OUT_W-1:0] res_slot;
  logic [STATUS_W-1:0]   out_status;
  logic [SLOT_OUT_W-1:0] out_slot;

  logic                  in_acc;
  logic                  room;
  logic                  kind_ok;
  logic                  home_start;
  logic                  home_done;
  logic [SLOT_W-1:0]     home;
  logic                  issue;
  logic [SLOT_W:0]       slot_sum;
  logic [SLOT_W:0]       stride_sum;
  logic [SLOT_W-1:0]     pslot_next;
  logic [SLOT_W-1:0]     stride_next;
  slot_t                 rd_entry;
  logic                  term;
  logic                  term_ok;
  logic [STATUS_W-1:0]   term_status;
  logic                  wr_en;
  logic [SLOT_W-1:0]     wr_addr;
  slot_t                 wr_data;

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = s_tvalid && s_tready;
  assign room      = CMP_W'(element_count) < CMP_W'(load_limit);
  assign kind_ok   = (s_tuser == KIND_INSERT) || (s_tuser == KIND_SEARCH) ||
                     (s_tuser == KIND_REMOVE);
  assign home_start = in_acc && kind_ok && ((s_tuser != KIND_INSERT) || room);

  qph_home #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .SLOT_W      (SLOT_W)
  ) u_home (
    .clk   (clk),
    .rst   (rst),
    .start (home_start),
    .key   (s_tdata[KEY_W-1:0]),
    .done  (home_done),
    .home  (home)
  );

  // next probe slot and stride (stepped by two), both kept below the table size
  always_comb begin
    slot_sum    = {1'b0, pslot} + {1'b0, stride};
    stride_sum  = {1'b0, stride} + (SLOT_W+1)'(2);
    pslot_next  = (slot_sum >= (SLOT_W+1)'(TABLE_SLOTS)) ?
                  SLOT_W'(slot_sum - (SLOT_W+1)'(TABLE_SLOTS)) : slot_sum[SLOT_W-1:0];
    stride_next = (stride_sum >= (SLOT_W+1)'(TABLE_SLOTS)) ?
                  SLOT_W'(stride_sum - (SLOT_W+1)'(TABLE_SLOTS)) : stride_sum[SLOT_W-1:0];
  end

  assign issue = (state == ST_PROBE) && (issued != PCNT_W'(TABLE_SLOTS));

  // evaluate the slot returned by the ram
  always_comb begin
    term        = 1'b0;
    term_ok     = 1'b0;
    term_status = ST_MISSING;
    if ((state == ST_PROBE) && rd_vld) begin
      if (req_kind == KIND_INSERT) begin
        if (!rd_entry.used || rd_entry.dead) begin
          term    = 1'b1;
          term_ok = 1'b1;
        end else if (rd_last) begin
          term        = 1'b1;
          term_status = ST_FULL;
        end
      end else begin
        if (!rd_entry.used) begin
          term = 1'b1;
        end else if (!rd_entry.dead && (rd_entry.key == req_key)) begin
          term    = 1'b1;
          term_ok = 1'b1;
        end else if (rd_last) begin
          term = 1'b1;
        end
      end
      if (term_ok) begin
        term_status = ST_OK;
      end
    end
  end

  // ram write: clearing pass, insert or tombstone
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = rd_slot;
    wr_data = '0;
    if (state == ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr;
    end else if (term_ok && (req_kind == KIND_INSERT)) begin
      wr_en        = 1'b1;
      wr_data.used = 1'b1;
      wr_data.key  = req_key;
    end else if (term_ok && (req_kind == KIND_REMOVE)) begin
      wr_en        = 1'b1;
      wr_data.used = 1'b1;
      wr_data.dead = 1'b1;
      wr_data.key  = rd_entry.key;
    end
  end

  qph_ram #(
    .DEPTH  (TABLE_SLOTS),
    .ADDR_W (SLOT_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (issue),
    .rd_addr (pslot),
    .rd_data (rd_entry)
  );

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      load_limit <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      load_limit <= cfg_data;
    end
  end

  // request sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      clr_addr      <= '0;
      element_count <= '0;
      rd_vld        <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == SLOT_W'(TABLE_SLOTS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            state <= home_start ? ST_HOME : ST_FINISH;
          end
        end
        ST_HOME: begin
          if (home_done) begin
            state <= ST_PROBE;
          end
        end
        ST_PROBE: begin
          rd_vld <= issue;
          if (term) begin
            rd_vld <= 1'b0;
            state  <= ST_FINISH;
            if (term_ok && (req_kind == KIND_INSERT)) begin
              element_count <= element_count + 1'b1;
            end else if (term_ok && (req_kind == KIND_REMOVE) && (element_count != '0)) begin
              element_count <= element_count - 1'b1;
            end
          end
        end
        ST_FINISH: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // request, probe and result datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_kind   <= s_tuser;
      req_key    <= s_tdata[KEY_W-1:0];
      res_slot   <= '0;
      res_status <= (kind_ok && (s_tuser == KIND_INSERT)) ? ST_FULL : ST_MISSING;
    end
    if ((state == ST_HOME) && home_done) begin
      pslot  <= home;
      stride <= SLOT_W'(1);
      issued <= '0;
    end else if (issue) begin
      pslot   <= pslot_next;
      stride  <= stride_next;
      issued  <= issued + 1'b1;
      rd_slot <= pslot;
      rd_last <= (issued == PCNT_W'(TABLE_SLOTS - 1));
    end
    if (term) begin
      res_status <= term_status;
      res_slot   <= term_ok ? SLOT_OUT_W'(rd_slot) : '0;
    end
    if ((state == ST_FINISH) && (!m_tvalid || m_tready)) begin
      out_status <= res_status;
      out_slot   <= res_slot;
    end
  end

  assign m_tdata = M_TDATA_W'({out_slot, out_status});

endmodule
